>>> hdl/xor_ring_pattern_pixel_assert.svh
// Assertion helpers shared by the ring pattern RTL.
`ifndef XOR_RING_PATTERN_PIXEL_ASSERT_SVH
`define XOR_RING_PATTERN_PIXEL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define XRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define XRP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/xrp_pkg.sv
`timescale 1ns / 1ps
package xrp_pkg;

  localparam int CFG_BITS = 11;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_COLOR_STYLE  = 2'd2;

  localparam logic [1:0] STYLE_BLACK   = 2'd0;
  localparam logic [1:0] STYLE_FIXED   = 2'd1;
  localparam logic [1:0] STYLE_TEXTURE = 2'd2;

  localparam logic [23:0] COLOR_HIT  = 24'h003050;
  localparam logic [23:0] COLOR_MISS = 24'h005030;

  localparam logic [CFG_BITS-1:0] RESET_WIDTH  = 11'd1024;
  localparam logic [CFG_BITS-1:0] RESET_HEIGHT = 11'd768;

  // Only the low byte of x, y and t reaches the texture colors.
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] t;
  } pix_t;

endpackage

>>> hdl/xrp_front.sv
`timescale 1ns / 1ps
module xrp_front #(
  parameter int COORD_BITS = 11,
  parameter int MAG_BITS   = 12,
  parameter int SUM_BITS   = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            valid_in,
  input  logic [COORD_BITS-1:0]           x,
  input  logic [COORD_BITS-1:0]           y,
  input  logic [1:0][COORD_BITS-1:0]      shift_x,
  input  logic [1:0][COORD_BITS-1:0]      shift_y,
  input  logic [7:0]                      t,
  input  logic [xrp_pkg::CFG_BITS-1:0]    frame_width,
  input  logic [xrp_pkg::CFG_BITS-1:0]    frame_height,
  output logic                            valid_out,
  output logic [1:0][SUM_BITS-1:0]        sum,
  output xrp_pkg::pix_t                   pix_out
);
  import xrp_pkg::*;

  localparam int DW = MAG_BITS + 1;

  logic [2:0]                 vld;
  pix_t                       pix_a, pix_b, pix_c;
  logic [1:0][MAG_BITS-1:0]   ax, ay;
  logic [1:0][2*MAG_BITS-1:0] sqx, sqy;
  logic [1:0][MAG_BITS-1:0]   ax_next, ay_next;

  always_comb begin
    logic signed [DW-1:0] xs, ys, hw, hh, dx, dy;
    xs = $signed({{(DW-COORD_BITS){1'b0}}, x});
    ys = $signed({{(DW-COORD_BITS){1'b0}}, y});
    hw = $signed({{(DW-CFG_BITS+1){1'b0}}, frame_width[CFG_BITS-1:1]});
    hh = $signed({{(DW-CFG_BITS+1){1'b0}}, frame_height[CFG_BITS-1:1]});
    for (int j = 0; j < 2; j++) begin
      dx = xs - hw + $signed({{(DW-COORD_BITS){shift_x[j][COORD_BITS-1]}}, shift_x[j]});
      dy = ys - hh + $signed({{(DW-COORD_BITS){shift_y[j][COORD_BITS-1]}}, shift_y[j]});
      if (dx[DW-1]) dx = -dx;
      if (dy[DW-1]) dy = -dy;
      ax_next[j] = dx[MAG_BITS-1:0];
      ay_next[j] = dy[MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], valid_in};
    end
  end

  // Offsets, then squares, then the sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      ax    <= ax_next;
      ay    <= ay_next;
      pix_a <= '{x: x[7:0], y: y[7:0], t: t};
      for (int j = 0; j < 2; j++) begin
        sqx[j] <= ax[j] * ax[j];
        sqy[j] <= ay[j] * ay[j];
        sum[j] <= SUM_BITS'(sqx[j]) + SUM_BITS'(sqy[j]);
      end
      pix_b <= pix_a;
      pix_c <= pix_b;
    end
  end

  assign valid_out = vld[2];
  assign pix_out   = pix_c;

endmodule

>>> hdl/xrp_sqrt_cell.sv
`timescale 1ns / 1ps
module xrp_sqrt_cell #(
  parameter int ROOT_BITS = 13,
  parameter int SUM_BITS  = 25,
  parameter int STEP      = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid_in,
  input  logic [1:0][SUM_BITS-1:0]  rem_in,
  input  logic [1:0][ROOT_BITS-1:0] root_in,
  input  xrp_pkg::pix_t             pix_in,
  output logic                      valid_out,
  output logic [1:0][SUM_BITS-1:0]  rem_out,
  output logic [1:0][ROOT_BITS-1:0] root_out,
  output xrp_pkg::pix_t             pix_out
);
  import xrp_pkg::*;

  localparam int B  = ROOT_BITS - 1 - STEP;
  localparam int TW = SUM_BITS + 2;

  logic [1:0][SUM_BITS-1:0]  rem_next;
  logic [1:0][ROOT_BITS-1:0] root_next;

  // Try to set root bit B: subtract (root << (B+1)) + 4^B when it fits.
  always_comb begin
    logic [TW-1:0] trial;
    for (int j = 0; j < 2; j++) begin
      trial = (TW'(root_in[j]) << (B + 1)) + (TW'(1) << (2 * B));
      if ({2'b00, rem_in[j]} >= trial) begin
        rem_next[j]  = SUM_BITS'({2'b00, rem_in[j]} - trial);
        root_next[j] = root_in[j] | (ROOT_BITS'(1) << B);
      end else begin
        rem_next[j]  = rem_in[j];
        root_next[j] = root_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      root_out <= root_next;
      pix_out  <= pix_in;
    end
  end

endmodule

>>> hdl/xrp_mod_cell.sv
`timescale 1ns / 1ps
module xrp_mod_cell #(
  parameter int ROOT_BITS = 13,
  parameter int PER_BITS  = 7,
  parameter int STEP      = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [PER_BITS-1:0]       period,
  input  logic                      valid_in,
  input  logic [1:0][ROOT_BITS-1:0] dist_in,
  input  logic [1:0][ROOT_BITS-1:0] rem_in,
  input  xrp_pkg::pix_t             pix_in,
  output logic                      valid_out,
  output logic [1:0][ROOT_BITS-1:0] dist_out,
  output logic [1:0][ROOT_BITS-1:0] rem_out,
  output xrp_pkg::pix_t             pix_out
);
  import xrp_pkg::*;

  localparam int BIT = ROOT_BITS - 1 - STEP;

  logic [1:0][ROOT_BITS-1:0] rem_next;

  // Shift in one dividend bit; subtract the period when it fits.
  // A zero period always fits, so the dividend passes through.
  always_comb begin
    logic [ROOT_BITS:0] trial;
    for (int j = 0; j < 2; j++) begin
      trial = {rem_in[j], dist_in[j][BIT]};
      if (trial >= (ROOT_BITS + 1)'(period)) begin
        trial = trial - (ROOT_BITS + 1)'(period);
      end
      rem_next[j] = trial[ROOT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_out <= dist_in;
      rem_out  <= rem_next;
      pix_out  <= pix_in;
    end
  end

endmodule

>>> hdl/xor_ring_pattern_pixel.sv
`timescale 1ns / 1ps
// Two-ring XOR pattern generator, one pixel color per request.
// Input channel: in_valid / in_stall with pixel_x, pixel_y, the two center
// shifts and time_step. Output channel: out_valid / out_stall with
// pixel_color (RGB888, red in 23:16). A request moves when valid is high
// and stall is low at a rising edge.
// Configuration: cfg_write with cfg_index (0 width, 1 height, 2 style) and
// cfg_data; write only while no request is in flight.
// Throughput: one request per cycle while in_stall is low. A request passes
// through 3 front stages (offset, square, sum), R square-root cells, R modulo
// cells and the color register, where R = max(COORD_BITS, 11) + 2 is the
// root width.
// When the receiver stalls, the held color stays in the output register and
// the next finished color drops into a one-entry skid register; only when
// the skid is full does in_stall rise and the whole cell chain hold.
// Synchronous reset empties the chain and skid and loads width 1024,
// height 768 and the two-color style.
module xor_ring_pattern_pixel #(
  parameter int COORD_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [COORD_BITS-1:0]         pixel_x,
  input  logic [COORD_BITS-1:0]         pixel_y,
  input  logic signed [COORD_BITS-1:0]  first_shift_x,
  input  logic signed [COORD_BITS-1:0]  first_shift_y,
  input  logic signed [COORD_BITS-1:0]  second_shift_x,
  input  logic signed [COORD_BITS-1:0]  second_shift_y,
  input  logic [7:0]                    time_step,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [23:0]                   pixel_color,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [xrp_pkg::CFG_BITS-1:0]  cfg_data
);
  import xrp_pkg::*;
  `include "xor_ring_pattern_pixel_assert.svh"

  // Offset magnitude bound: pixel below 2^COORD_BITS plus half width below 2^10.
  localparam int DBITS     = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
  localparam int MAG_BITS  = DBITS + 1;
  localparam int SUM_BITS  = 2 * MAG_BITS + 1;
  localparam int ROOT_BITS = MAG_BITS + 1;
  localparam int PER_BITS  = CFG_BITS - 4;
  localparam int THR_BITS  = CFG_BITS - 5;

  logic [CFG_BITS-1:0] frame_width, frame_height;
  logic [1:0]          color_style;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      color_style  <= STYLE_FIXED;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_COLOR_STYLE:  color_style  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [PER_BITS-1:0] period;
  logic [THR_BITS-1:0] threshold;
  assign period    = frame_width[CFG_BITS-1:4];
  assign threshold = frame_width[CFG_BITS-1:5];

  // Chain advances whenever the skid register is empty.
  logic skid_full;
  logic en;
  assign en       = !skid_full;
  assign in_stall = skid_full;

  logic                     f_valid;
  logic [1:0][SUM_BITS-1:0] f_sum;
  pix_t                     f_pix;

  xrp_front #(
    .COORD_BITS(COORD_BITS),
    .MAG_BITS  (MAG_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .valid_in    (in_valid),
    .x           (pixel_x),
    .y           (pixel_y),
    .shift_x     ({second_shift_x, first_shift_x}),
    .shift_y     ({second_shift_y, first_shift_y}),
    .t           (time_step),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .valid_out   (f_valid),
    .sum         (f_sum),
    .pix_out     (f_pix)
  );

  // Square-root cells: one root bit each, both centers side by side.
  logic                      sq_valid [ROOT_BITS+1];
  logic [1:0][SUM_BITS-1:0]  sq_rem   [ROOT_BITS+1];
  logic [1:0][ROOT_BITS-1:0] sq_root  [ROOT_BITS+1];
  pix_t                      sq_pix   [ROOT_BITS+1];

  assign sq_valid[0] = f_valid;
  assign sq_rem[0]   = f_sum;
  assign sq_root[0]  = '0;
  assign sq_pix[0]   = f_pix;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    xrp_sqrt_cell #(
      .ROOT_BITS(ROOT_BITS),
      .SUM_BITS (SUM_BITS),
      .STEP     (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (sq_valid[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .pix_in   (sq_pix[k]),
      .valid_out(sq_valid[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .pix_out  (sq_pix[k+1])
    );
  end

  // Modulo cells: restoring division of the distance by the ring period.
  logic                      md_valid [ROOT_BITS+1];
  logic [1:0][ROOT_BITS-1:0] md_dist  [ROOT_BITS+1];
  logic [1:0][ROOT_BITS-1:0] md_rem   [ROOT_BITS+1];
  pix_t                      md_pix   [ROOT_BITS+1];

  assign md_valid[0] = sq_valid[ROOT_BITS];
  assign md_dist[0]  = sq_root[ROOT_BITS];
  assign md_rem[0]   = '0;
  assign md_pix[0]   = sq_pix[ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_mod
    xrp_mod_cell #(
      .ROOT_BITS(ROOT_BITS),
      .PER_BITS (PER_BITS),
      .STEP     (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .period   (period),
      .valid_in (md_valid[k]),
      .dist_in  (md_dist[k]),
      .rem_in   (md_rem[k]),
      .pix_in   (md_pix[k]),
      .valid_out(md_valid[k+1]),
      .dist_out (md_dist[k+1]),
      .rem_out  (md_rem[k+1]),
      .pix_out  (md_pix[k+1])
    );
  end

  // Ring bits, XOR, and the color style.
  logic        last_valid;
  logic        hit;
  logic [23:0] color;
  pix_t        lp;

  assign last_valid = md_valid[ROOT_BITS];
  assign lp         = md_pix[ROOT_BITS];
  assign hit = (md_rem[ROOT_BITS][0] > ROOT_BITS'(threshold))
             ^ (md_rem[ROOT_BITS][1] > ROOT_BITS'(threshold));

  always_comb begin
    logic [7:0] r, g, b;
    r = lp.y ^ (lp.x + lp.t);
    g = lp.x ^ (lp.y + lp.t);
    b = (lp.x - lp.t) ^ lp.y;
    unique case (color_style)
      STYLE_FIXED:   color = hit ? COLOR_HIT : COLOR_MISS;
      STYLE_TEXTURE: color = hit ? ~{r, g, b} : {r, g, b};
      default:       color = '0;
    endcase
  end

  // Output register plus one-entry skid.
  logic [23:0] skid_color;
  logic        out_take;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        skid_full <= 1'b0;
      end
    end else if (last_valid) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!out_stall) begin
        pixel_color <= skid_color;
      end
    end else if (last_valid) begin
      if (!out_valid || out_take) begin
        pixel_color <= color;
      end else begin
        skid_color <= color;
      end
    end
  end

  `XRP_ASSERT_IMP(a_skid_has_out, clk, rst, skid_full, out_valid, "skid full without output")
  `XRP_ASSERT_NXT(a_skid_fills, clk, rst, last_valid && !skid_full && out_valid && out_stall, skid_full, "finished color lost while output stalled")
  `XRP_ASSERT_NXT(a_skid_drains, clk, rst, skid_full && !out_stall, !skid_full && out_valid, "skid failed to drain")

endmodule
